// ===== src/bsd_pkg.sv =====
package bsd_pkg;

   // encodings as reported on the result channel
   localparam logic [1:0] ENC_ASCII = 2'd0;
   localparam logic [1:0] ENC_UTF8  = 2'd1;
   localparam logic [1:0] ENC_LE16  = 2'd2;
   localparam logic [1:0] ENC_BE16  = 2'd3;

   // sniff phases
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_REPEAT = 2'd1;
   localparam logic [1:0] PH_DECODE = 2'd2;

   // sniff verdicts, low two bits of a mark verdict give its encoding
   localparam logic [2:0] VERD_UTF8 = 3'd1;
   localparam logic [2:0] VERD_LE16 = 3'd2;
   localparam logic [2:0] VERD_BE16 = 3'd3;
   localparam logic [2:0] VERD_WAIT = 3'd4;
   localparam logic [2:0] VERD_NONE = 3'd5;

   // mark bytes and substitution unit
   localparam logic [7:0]  BYTE_FF     = 8'hff;
   localparam logic [7:0]  BYTE_FE     = 8'hfe;
   localparam logic [7:0]  BYTE_EF     = 8'hef;
   localparam logic [7:0]  BYTE_BB     = 8'hbb;
   localparam logic [7:0]  BYTE_BF     = 8'hbf;
   localparam logic [15:0] UNIT_QMARK  = 16'h003f;

   localparam int BSD_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [15:0] accum;
      logic [1:0]  remaining;
      logic [7:0]  low_byte;
      logic        half_held;
   } dec_state_type;

   localparam dec_state_type DEC_CLEAR = '0;

   typedef struct packed {
      dec_state_type st;
      logic          emit;
      logic [15:0]   unit;
   } dec_result_type;

   // one queue entry holds all results of one request
   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][15:0] units;
      logic [1:0]       enc;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // one byte through the decoder
   function automatic dec_result_type decode_byte(logic [1:0] mode, dec_state_type st,
                                                  logic [7:0] b);
      dec_result_type r;
      r.st   = st;
      r.emit = 1'b0;
      r.unit = '0;
      unique case (mode)
         ENC_ASCII: begin
            r.emit = 1'b1;
            r.unit = {8'h00, b};
         end
         ENC_UTF8: begin
            priority if (st.remaining == 2'd2) begin
               r.st.accum     = st.accum | {4'h0, b[5:0], 6'h00};
               r.st.remaining = 2'd1;
            end else if (st.remaining == 2'd1) begin
               r.emit         = 1'b1;
               r.unit         = st.accum | {10'h000, b[5:0]};
               r.st.accum     = '0;
               r.st.remaining = 2'd0;
            end else if (!b[7]) begin
               r.emit = 1'b1;
               r.unit = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
               r.st.accum     = {5'h00, b[4:0], 6'h00};
               r.st.remaining = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               r.st.accum     = {b[3:0], 12'h000};
               r.st.remaining = 2'd2;
            end else begin
               r.emit = 1'b1;
               r.unit = UNIT_QMARK;
            end
         end
         ENC_LE16: begin
            if (st.half_held) begin
               r.emit         = 1'b1;
               r.unit         = {b, st.low_byte};
               r.st.half_held = 1'b0;
            end else begin
               r.st.low_byte  = b;
               r.st.half_held = 1'b1;
            end
         end
         ENC_BE16: begin
            if (st.half_held) begin
               r.emit         = 1'b1;
               r.unit         = {st.low_byte, b};
               r.st.half_held = 1'b0;
            end else begin
               r.st.low_byte  = b;
               r.st.half_held = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // verdict on the sniff buffer holding n bytes
   function automatic logic [2:0] judge_sniff(logic [1:0] n, logic [7:0] b0, logic [7:0] b1,
                                              logic [7:0] b2, logic at_end);
      logic [2:0] v;
      v = VERD_NONE;
      if (n <= 2'd1) begin
         if (b0 == BYTE_FF || b0 == BYTE_FE || b0 == BYTE_EF) begin
            v = at_end ? VERD_NONE : VERD_WAIT;
         end
      end else if (n == 2'd2) begin
         if (b0 == BYTE_FF && b1 == BYTE_FE) begin
            v = VERD_LE16;
         end else if (b0 == BYTE_FE && b1 == BYTE_FF) begin
            v = VERD_BE16;
         end else if (b0 == BYTE_EF && b1 == BYTE_BB) begin
            v = at_end ? VERD_NONE : VERD_WAIT;
         end
      end else if (b0 == BYTE_EF && b1 == BYTE_BB && b2 == BYTE_BF) begin
         v = VERD_UTF8;
      end
      return v;
   endfunction

endpackage

// ===== src/bsd_req_if.sv =====
interface bsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_end;
   logic       new_text;

   modport source (output valid, output data_byte, output chunk_end, output new_text,
                   input ready);
   modport sink (input valid, input data_byte, input chunk_end, input new_text,
                 output ready);
endinterface

// ===== src/bsd_rsp_if.sv =====
interface bsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [1:0]  encoding_now;
   logic        last_of_run;

   modport source (output valid, output code_unit, output encoding_now, output last_of_run,
                   input ready);
   modport sink (input valid, input code_unit, input encoding_now, input last_of_run,
                 output ready);
endinterface

// ===== src/bom_sniff_text_decoder_unit.sv =====
// byte-order-mark sniffing text decoder
//
// req_chan carries one text byte per request with chunk_end and new_text
// flags; rsp_chan returns 16-bit code units, the encoding in use and
// last_of_run on the final unit caused by one request. A request may cause
// zero to three units; one that causes none produces nothing on rsp_chan.
// Throughput: one request per cycle while the queue has space. All sniff and
// decode work of a request is done in the cycle it is accepted, and its units
// go into a queue of QueueDepth entries (one entry per request that causes
// units). The result stage drains one unit per cycle while rsp_chan is
// ready. A request's units are written to the queue, then loaded one by one
// into the result register. When rsp_chan stalls, the queue keeps taking
// requests until it is full, then req_chan.ready drops. Reset (synchronous)
// empties the queue and the result register and returns the decoder to ASCII
// with nothing emitted; new_text does the same for decoder state only.
module bom_sniff_text_decoder_unit #(
   parameter int QueueDepth = bsd_pkg::BSD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   bsd_req_if.sink    req_chan,
   bsd_rsp_if.source  rsp_chan
);
   import bsd_pkg::*;

   push_type push;
   head_type head;
   logic     space_ok;
   logic     pop;

   // sniff and decode
   bsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .space_ok (space_ok),
      .push     (push)
   );

   // per-request result queue
   bsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .head     (head),
      .pop      (pop)
   );

   // unit-by-unit output
   bsd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

   // no result right after reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // units of one run follow back to back with one encoding
   a_run_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=>
      (rsp_chan.valid && rsp_chan.encoding_now == $past(rsp_chan.encoding_now)))
      else $error("run of units broken");

endmodule

// ===== src/bsd_front.sv =====
module bsd_front (
   input  logic               clock,
   input  logic               reset,
   bsd_req_if.sink            req,
   input  logic               space_ok,
   output bsd_pkg::push_type  push
);
   import bsd_pkg::*;

   logic [1:0]       mode_ff, mode_in;
   logic             empty_ff, empty_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       count_ff, count_in;
   dec_state_type    dec_ff, dec_in;
   logic [2:0][7:0]  sniff_ff, sniff_in;

   logic             accept;
   logic [1:0]       s_mode, s_phase, s_count;
   logic             s_empty;
   dec_state_type    s_dec;
   logic [1:0]       idx, cnt;
   logic [2:0]       verdict;
   logic [2:0]       en;
   logic [2:0][7:0]  dbyte;
   dec_result_type   r0, r1, r2;
   dec_state_type    st1, st2, st3;
   logic [2:0]       emits;
   logic [2:0][15:0] cand;
   logic [2:0][15:0] units;
   logic [1:0]       n;

   assign req.ready = space_ok;
   assign accept    = req.valid && space_ok;

   // state as seen by this request, fresh text clears it first
   always_comb begin
      if (req.new_text) begin
         s_mode  = ENC_ASCII;
         s_empty = 1'b1;
         s_phase = PH_FIRST;
         s_count = 2'd0;
         s_dec   = DEC_CLEAR;
      end else begin
         s_mode  = mode_ff;
         s_empty = empty_ff;
         s_phase = phase_ff;
         s_count = count_ff;
         s_dec   = dec_ff;
      end
   end

   // sniffing and selection of bytes to decode
   always_comb begin
      mode_in  = s_mode;
      phase_in = s_phase;
      count_in = s_count;
      sniff_in = sniff_ff;
      en       = 3'b000;
      dbyte    = sniff_ff;
      idx      = (s_count == 2'd3) ? 2'd2 : s_count;
      cnt      = idx + 2'd1;
      verdict  = VERD_WAIT;
      if (s_phase == PH_FIRST || s_phase == PH_REPEAT) begin
         sniff_in[idx] = req.data_byte;
         verdict = judge_sniff(cnt, sniff_in[0], sniff_in[1], sniff_in[2], req.chunk_end);
         if (verdict == VERD_NONE) begin
            if (s_phase == PH_FIRST) begin
               mode_in = ENC_ASCII;
            end
            phase_in = PH_DECODE;
            dbyte    = sniff_in;
            en       = (cnt == 2'd1) ? 3'b001 : ((cnt == 2'd2) ? 3'b011 : 3'b111);
            count_in = 2'd0;
         end else if (verdict != VERD_WAIT) begin
            if (s_phase == PH_FIRST) begin
               mode_in  = verdict[1:0];
               phase_in = PH_REPEAT;
            end else begin
               phase_in = (verdict[1:0] == s_mode) ? PH_REPEAT : PH_DECODE;
            end
            count_in = 2'd0;
         end else begin
            count_in = cnt;
         end
      end else begin
         en       = 3'b001;
         dbyte[0] = req.data_byte;
      end
      // end of chunk restarts the sniff buffer
      if (req.chunk_end) begin
         count_in = 2'd0;
      end
   end

   // up to three decode steps in a row
   always_comb begin
      r0  = decode_byte(mode_in, s_dec, dbyte[0]);
      st1 = en[0] ? r0.st : s_dec;
      r1  = decode_byte(mode_in, st1, dbyte[1]);
      st2 = en[1] ? r1.st : st1;
      r2  = decode_byte(mode_in, st2, dbyte[2]);
      st3 = en[2] ? r2.st : st2;
      emits = en & {r2.emit, r1.emit, r0.emit};
      cand  = {r2.unit, r1.unit, r0.unit};
   end

   // pack emitted units in order
   always_comb begin
      units = '0;
      n     = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (emits[i]) begin
            units[n] = cand[i];
            n        = n + 2'd1;
         end
      end
   end

   // end of chunk drops partial sequences
   always_comb begin
      empty_in = s_empty & ~(|emits);
      dec_in   = st3;
      if (req.chunk_end) begin
         dec_in = DEC_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ENC_ASCII;
         empty_ff <= 1'b1;
         phase_ff <= PH_FIRST;
         count_ff <= 2'd0;
         dec_ff   <= DEC_CLEAR;
      end else if (accept) begin
         mode_ff  <= mode_in;
         empty_ff <= empty_in;
         phase_ff <= req.chunk_end ? (empty_in ? PH_FIRST : PH_DECODE) : phase_in;
         count_ff <= count_in;
         dec_ff   <= dec_in;
      end
   end

   // sniff buffer, read only where written in the same sniff
   always_ff @(posedge clock) begin
      if (accept) begin
         sniff_ff <= sniff_in;
      end
   end

   // results of this request toward the queue
   assign push.push        = accept && (n != 2'd0);
   assign push.entry.count = n;
   assign push.entry.units = units;
   assign push.entry.enc   = mode_in;

endmodule

// ===== src/bsd_queue.sv =====
module bsd_queue #(
   parameter int Depth = bsd_pkg::BSD_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  bsd_pkg::push_type  push,
   output logic               space_ok,
   output bsd_pkg::head_type  head,
   input  logic               pop
);
   import bsd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LvlW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]   level_ff, level_in;
   logic              do_push, do_pop;

   assign space_ok   = (level_ff != LvlW'(Depth));
   assign head.valid = (level_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.push && space_ok;
   assign do_pop     = pop && head.valid;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== src/bsd_back.sv =====
module bsd_back (
   input  logic               clock,
   input  logic               reset,
   input  bsd_pkg::head_type  head,
   output logic               pop,
   bsd_rsp_if.source          rsp
);
   import bsd_pkg::*;

   logic [1:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [15:0] unit_ff;
   logic [1:0]  enc_ff;
   logic        last_ff;
   logic        load, take, is_last;

   // output register reloads when empty or taken
   assign load    = !valid_ff || rsp.ready;
   assign take    = load && head.valid;
   assign is_last = (pos_ff + 2'd1 == head.entry.count);
   assign pop     = take && is_last;

   always_comb begin
      valid_in = load ? head.valid : valid_ff;
      pos_in   = pos_ff;
      if (take) begin
         pos_in = is_last ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         unit_ff <= head.entry.units[pos_ff];
         enc_ff  <= head.entry.enc;
         last_ff <= is_last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.code_unit    = unit_ff;
   assign rsp.encoding_now = enc_ff;
   assign rsp.last_of_run  = last_ff;

endmodule
